>>> rtl/core/p2p_pkg.sv
// ---------------------------------------------------------------------------
// p2p_pkg
// Types, widths and constants shared by the point-to-pixel projection unit.
// ---------------------------------------------------------------------------
package p2p_pkg;

   localparam int FRACTION_BITS = 16;

   localparam int IN_W    = 32;                       // coefficient and coordinate width
   localparam int OUT_W   = 48;                       // result width, Q32.F
   localparam int CFG_W   = 14;                       // screen size width
   localparam int IDX_W   = 4;                        // coefficient index width
   localparam int N_COEF  = 16;

   localparam int TERM_W  = 2 * IN_W - FRACTION_BITS; // product after floor shift
   localparam int CLIP_W  = TERM_W + 2;               // sum of three terms and translation
   localparam int D_W     = CLIP_W;                   // divisor 2*w
   localparam int SCALE_W = 20;                       // viewport scale magnitude
   localparam int OFF_W   = 20;                       // viewport offset
   localparam int PROD_W  = CLIP_W + SCALE_W;
   localparam int NUM_W   = PROD_W + FRACTION_BITS;   // dividend
   localparam int CAP_SH  = 50;                       // quotient clamps at 2**CAP_SH
   localparam int HI_W    = NUM_W - CAP_SH;
   localparam int CMP_W   = (HI_W > D_W) ? HI_W : D_W;
   localparam int BPS     = 2;                        // quotient bits per stage
   localparam int DIV_STAGES = CAP_SH / BPS;
   localparam int VAL_W   = CAP_SH + 3;
   localparam int LANE_LAT = DIV_STAGES + 3;          // register stages through one lane
   localparam int PIPE_LAT = LANE_LAT + 2;            // input to result register

   localparam logic [SCALE_W-1:0] DEPTH_SCALE_MAG = SCALE_W'(999999);
   localparam logic [OFF_W-1:0]   DEPTH_OFFSET    = OFF_W'(1000001);

   localparam logic signed [OUT_W-1:0] ONE_FX     = OUT_W'(1) <<< FRACTION_BITS;
   localparam logic signed [OUT_W-1:0] NEG_ONE_FX = -ONE_FX;
   localparam logic signed [OUT_W-1:0] OUT_MAX    = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN    = {1'b1, {(OUT_W-1){1'b0}}};

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);

endpackage

>>> rtl/core/p2p_if.sv
// ---------------------------------------------------------------------------
// p2p channel interfaces
// Request, response and register-write channels with valid/ready.
// ---------------------------------------------------------------------------
interface p2p_req_if;
   import p2p_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [IDX_W-1:0]         coef_index;
   logic signed [IN_W-1:0]   coef_value;
   logic signed [IN_W-1:0]   point_x;
   logic signed [IN_W-1:0]   point_y;
   logic signed [IN_W-1:0]   point_z;
   modport source (output valid, operation, coef_index, coef_value, point_x, point_y,
                   point_z, input ready);
   modport sink   (input valid, operation, coef_index, coef_value, point_x, point_y,
                   point_z, output ready);
endinterface

interface p2p_rsp_if;
   import p2p_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  pixel_x;
   logic signed [OUT_W-1:0]  pixel_y;
   logic signed [OUT_W-1:0]  depth;
   logic                     behind_camera;
   modport source (output valid, pixel_x, pixel_y, depth, behind_camera, input ready);
   modport sink   (input valid, pixel_x, pixel_y, depth, behind_camera, output ready);
endinterface

interface p2p_csr_if;
   import p2p_pkg::*;
   logic              valid;
   logic              ready;
   logic              index;
   logic [CFG_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/point_to_pixel_projection_unit.sv
// ---------------------------------------------------------------------------
// point_to_pixel_projection_unit
// Loadable 4x4 transform, perspective divide and viewport mapping.
//
//   channel  dir  carries
//   req      in   coefficient load or world point
//   rsp      out  pixel x/y, depth, behind flag (points only)
//   csr      in   screen width / height writes
//
// One transaction per cycle while no result is stalled. A point passes through
// matrix product (2 stages), lane product and clamp check (2), divider
// (25 stages of 2 quotient bits) and output saturation (1) to its result.
// Loads update the matrix at acceptance and flow no further.
// A stalled result freezes the whole pipeline; req ready falls only then.
// Reset loads the identity matrix and a 1920x1080 viewport.
// ---------------------------------------------------------------------------
module point_to_pixel_projection_unit (
   input  logic      clock,
   input  logic      reset,
   p2p_req_if.sink   req_bus,
   p2p_rsp_if.source rsp_bus,
   p2p_csr_if.sink   csr_bus
);
   import p2p_pkg::*;

   logic advance;
   logic accept;
   logic valid_ff [PIPE_LAT];
   logic beh_ff   [LANE_LAT];

   assign advance       = !valid_ff[PIPE_LAT-1] || rsp_bus.ready;
   assign accept        = req_bus.valid && advance;
   assign req_bus.ready = advance;

   // registers
   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_bus.data;
            CSR_SCREEN_HEIGHT: height_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // transform matrix, column-major
   logic signed [IN_W-1:0] matrix_ff [N_COEF];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_COEF; i++) begin
            matrix_ff[i] <= (i % 5 == 0) ? (IN_W'(1) << FRACTION_BITS) : '0;
         end
      end else if (accept && req_bus.operation == OP_LOAD) begin
         matrix_ff[req_bus.coef_index] <= req_bus.coef_value;
      end
   end

   // stage 1: products, floor-shifted
   logic signed [IN_W-1:0]   pt [3];
   logic signed [TERM_W-1:0] term_in [4][3];
   logic signed [TERM_W-1:0] term_ff [4][3];
   logic signed [IN_W-1:0]   trans_ff [4];

   assign pt[0] = req_bus.point_x;
   assign pt[1] = req_bus.point_y;
   assign pt[2] = req_bus.point_z;

   always_comb begin
      logic signed [2*IN_W-1:0] full;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            full          = matrix_ff[c*4+r] * pt[c];
            term_in[r][c] = full[2*IN_W-1:FRACTION_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         term_ff  <= term_in;
         for (int r = 0; r < 4; r++) begin
            trans_ff[r] <= matrix_ff[12+r];
         end
      end
   end

   // stage 2: clip coordinates
   logic signed [CLIP_W-1:0] clip_ff [4];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 4; r++) begin
            clip_ff[r] <= CLIP_W'(trans_ff[r]) + CLIP_W'(term_ff[r][0])
                        + CLIP_W'(term_ff[r][1]) + CLIP_W'(term_ff[r][2]);
         end
      end
   end

   logic           behind;
   logic [D_W-1:0] divisor;

   assign behind  = clip_ff[3][CLIP_W-1] || (clip_ff[3] == '0);
   assign divisor = {clip_ff[3][D_W-2:0], 1'b0};

   // valid and behind flags travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= accept && req_bus.operation == OP_POINT;
         for (int i = 1; i < PIPE_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beh_ff[0] <= behind;
         for (int i = 1; i < LANE_LAT; i++) begin
            beh_ff[i] <= beh_ff[i-1];
         end
      end
   end

   logic signed [OUT_W-1:0] lane_x;
   logic signed [OUT_W-1:0] lane_y;
   logic signed [OUT_W-1:0] lane_z;

   p2p_lane u_lane_x (
      .clock     (clock),
      .en        (advance),
      .c         (clip_ff[0]),
      .d         (divisor),
      .scale_mag (SCALE_W'(width_ff)),
      .scale_neg (1'b0),
      .offset    (OFF_W'(width_ff)),
      .result    (lane_x)
   );

   p2p_lane u_lane_y (
      .clock     (clock),
      .en        (advance),
      .c         (clip_ff[1]),
      .d         (divisor),
      .scale_mag (SCALE_W'(height_ff)),
      .scale_neg (1'b0),
      .offset    (OFF_W'(height_ff)),
      .result    (lane_y)
   );

   p2p_lane u_lane_z (
      .clock     (clock),
      .en        (advance),
      .c         (clip_ff[2]),
      .d         (divisor),
      .scale_mag (DEPTH_SCALE_MAG),
      .scale_neg (1'b1),
      .offset    (DEPTH_OFFSET),
      .result    (lane_z)
   );

   assign rsp_bus.valid         = valid_ff[PIPE_LAT-1];
   assign rsp_bus.behind_camera = beh_ff[LANE_LAT-1];
   assign rsp_bus.pixel_x       = beh_ff[LANE_LAT-1] ? NEG_ONE_FX : lane_x;
   assign rsp_bus.pixel_y       = beh_ff[LANE_LAT-1] ? NEG_ONE_FX : lane_y;
   assign rsp_bus.depth         = beh_ff[LANE_LAT-1] ? ONE_FX : lane_z;

endmodule

>>> rtl/core/p2p_lane.sv
// ---------------------------------------------------------------------------
// p2p_lane
// One viewport coordinate: |scale*c|<<F / d, clamped, signed, offset added,
// saturated. Restoring divider, BPS quotient bits per stage.
// ---------------------------------------------------------------------------
module p2p_lane (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [p2p_pkg::CLIP_W-1:0]    c,
   input  logic [p2p_pkg::D_W-1:0]              d,
   input  logic [p2p_pkg::SCALE_W-1:0]          scale_mag,
   input  logic                                 scale_neg,
   input  logic [p2p_pkg::OFF_W-1:0]            offset,
   output logic signed [p2p_pkg::OUT_W-1:0]     result
);
   import p2p_pkg::*;

   // stage 1: magnitude product
   logic [PROD_W-1:0] prod_ff;
   logic              neg1_ff;
   logic [D_W-1:0]    d1_ff;
   logic [OFF_W-1:0]  off1_ff;
   logic [CLIP_W-1:0] c_mag;

   assign c_mag = c[CLIP_W-1] ? CLIP_W'(-c) : CLIP_W'(c);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_W'(c_mag) * PROD_W'(scale_mag);
         neg1_ff <= c[CLIP_W-1] ^ scale_neg;
         d1_ff   <= d;
         off1_ff <= offset;
      end
   end

   // stage 2: clamp check and initial remainder
   logic [D_W-1:0]    r_ff   [DIV_STAGES+1];
   logic [CAP_SH-1:0] lo_ff  [DIV_STAGES+1];
   logic [CAP_SH-1:0] q_ff   [DIV_STAGES+1];
   logic              sat_ff [DIV_STAGES+1];
   logic              neg_ff [DIV_STAGES+1];
   logic [D_W-1:0]    d_ff   [DIV_STAGES+1];
   logic [OFF_W-1:0]  off_ff [DIV_STAGES+1];

   logic [NUM_W-1:0] num;
   logic [CMP_W-1:0] hi_ext;
   logic [CMP_W-1:0] d_ext;

   assign num    = {prod_ff, {FRACTION_BITS{1'b0}}};
   assign hi_ext = CMP_W'(num[NUM_W-1:CAP_SH]);
   assign d_ext  = CMP_W'(d1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= hi_ext[D_W-1:0];
         lo_ff[0]  <= num[CAP_SH-1:0];
         q_ff[0]   <= '0;
         sat_ff[0] <= (hi_ext >= d_ext);   // quotient reaches the clamp
         neg_ff[0] <= neg1_ff;
         d_ff[0]   <= d1_ff;
         off_ff[0] <= off1_ff;
      end
   end

   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
      logic [D_W-1:0]    r_in;
      logic [CAP_SH-1:0] lo_in;
      logic [CAP_SH-1:0] q_in;

      always_comb begin
         logic [D_W:0] t;
         r_in  = r_ff[s-1];
         lo_in = lo_ff[s-1];
         q_in  = q_ff[s-1];
         for (int b = 0; b < BPS; b++) begin
            t     = {r_in, lo_in[CAP_SH-1]};
            lo_in = lo_in << 1;
            if (t >= (D_W+1)'(d_ff[s-1])) begin
               t    = t - (D_W+1)'(d_ff[s-1]);
               q_in = {q_in[CAP_SH-2:0], 1'b1};
            end else begin
               q_in = {q_in[CAP_SH-2:0], 1'b0};
            end
            r_in = t[D_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= r_in;
            lo_ff[s]  <= lo_in;
            q_ff[s]   <= q_in;
            sat_ff[s] <= sat_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            d_ff[s]   <= d_ff[s-1];
            off_ff[s] <= off_ff[s-1];
         end
      end
   end

   // final stage: clamp, sign, offset, saturate
   localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'(OUT_MAX);
   localparam logic signed [VAL_W-1:0] SAT_LO = VAL_W'(OUT_MIN);

   logic [CAP_SH:0]          qm;
   logic signed [VAL_W-1:0]  sv;
   logic signed [VAL_W-1:0]  off_term;
   logic signed [VAL_W-1:0]  sum;
   logic signed [OUT_W-1:0]  res_in;
   logic signed [OUT_W-1:0]  res_ff;

   always_comb begin
      qm       = sat_ff[DIV_STAGES] ? ((CAP_SH+1)'(1) << CAP_SH)
                                    : {1'b0, q_ff[DIV_STAGES]};
      sv       = neg_ff[DIV_STAGES] ? -$signed(VAL_W'(qm)) : $signed(VAL_W'(qm));
      off_term = $signed(VAL_W'(off_ff[DIV_STAGES]) << (FRACTION_BITS - 1));
      sum      = sv + off_term;
      if (sum > SAT_HI)
         res_in = OUT_MAX;
      else if (sum < SAT_LO)
         res_in = OUT_MIN;
      else
         res_in = sum[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

>>> tb/point_to_pixel_projection_checker.sv
// ---------------------------------------------------------------------------
// point_to_pixel_projection_checker
// Watches the request, response and register channels of the projection
// unit. It keeps its own transform and viewport and predicts every point's
// pixel result. Each response is compared field by field, in order.
// ---------------------------------------------------------------------------
module point_to_pixel_projection_checker (
   input  logic clock,
   input  logic reset,
   p2p_req_if   req,
   p2p_rsp_if   rsp,
   p2p_csr_if   csr,
   output int   mismatches,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import p2p_pkg::*;

   typedef struct {
      logic signed [OUT_W-1:0] pixel_x;
      logic signed [OUT_W-1:0] pixel_y;
      logic signed [OUT_W-1:0] depth;
      logic                    behind;
   } pixel_type;

   pixel_type     pixel_q[$];
   longint        coef[N_COEF];
   longint        width_px, height_px;

   // scale*c*2^F/(2w) truncated toward zero, capped, offset, saturated
   function automatic logic signed [OUT_W-1:0] map_view(longint scale, longint offset,
                                                        longint c, longint w);
      bit          neg;
      bit [63:0]   sa, ca;
      bit [127:0]  num, quo;
      longint      val;
      neg = (scale < 0) != (c < 0);
      sa  = (scale < 0) ? -scale : scale;
      ca  = (c < 0) ? -c : c;
      num = (128'(sa) * 128'(ca)) << FRACTION_BITS;
      quo = num / (128'(w) << 1);
      if (quo > (128'(1) << CAP_SH)) quo = 128'(1) << CAP_SH;
      val = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
      val += offset * (longint'(1) <<< (FRACTION_BITS - 1));
      if (val > longint'(OUT_MAX)) val = longint'(OUT_MAX);
      if (val < longint'(OUT_MIN)) val = longint'(OUT_MIN);
      return val[OUT_W-1:0];
   endfunction

   function automatic pixel_type project_point(longint px, longint py, longint pz);
      longint pt[3];
      longint clip[4];
      pixel_type r;
      pt = '{px, py, pz};
      for (int row = 0; row < 4; row++) begin
         clip[row] = coef[12 + row];
         for (int col = 0; col < 3; col++)
            clip[row] += (coef[col * 4 + row] * pt[col]) >>> FRACTION_BITS;
      end
      if (clip[3] <= 0) begin
         r.pixel_x = NEG_ONE_FX;
         r.pixel_y = NEG_ONE_FX;
         r.depth   = ONE_FX;
         r.behind  = 1'b1;
      end else begin
         r.pixel_x = map_view(width_px, width_px, clip[0], clip[3]);
         r.pixel_y = map_view(height_px, height_px, clip[1], clip[3]);
         r.depth   = map_view(-longint'(DEPTH_SCALE_MAG), longint'(DEPTH_OFFSET),
                              clip[2], clip[3]);
         r.behind  = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         for (int i = 0; i < N_COEF; i++)
            coef[i] = (i % 5 == 0) ? (longint'(1) <<< FRACTION_BITS) : 0;
         width_px   = longint'(WIDTH_RESET);
         height_px  = longint'(HEIGHT_RESET);
         pixel_q.delete();
         mismatches = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_SCREEN_WIDTH) width_px = longint'(csr.data);
            else height_px = longint'(csr.data);
         end
         // response side first: a transaction accepted now cannot emerge now
         if (rsp.valid && rsp.ready) begin
            if (pixel_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t unexpected response x=%h y=%h d=%h b=%b", $realtime,
                           rsp.pixel_x, rsp.pixel_y, rsp.depth, rsp.behind_camera);
            end else begin
               want = pixel_q.pop_front();
               if (rsp.pixel_x !== want.pixel_x || rsp.pixel_y !== want.pixel_y ||
                   rsp.depth !== want.depth || rsp.behind_camera !== want.behind) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%t mismatch exp x=%h y=%h d=%h b=%b got x=%h y=%h d=%h b=%b",
                              $realtime, want.pixel_x, want.pixel_y, want.depth,
                              want.behind, rsp.pixel_x, rsp.pixel_y, rsp.depth,
                              rsp.behind_camera);
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.operation == OP_LOAD)
               coef[req.coef_index] = longint'(req.coef_value);
            else
               pixel_q.push_back(project_point(longint'(req.point_x),
                                               longint'(req.point_y),
                                               longint'(req.point_z)));
         end
      end
      pending = pixel_q.size();
   end
endmodule

>>> tb/point_to_pixel_projection_unit_tb.sv
// ---------------------------------------------------------------------------
// point_to_pixel_projection_unit_tb
// Directed and random coefficient loads and point projections across several
// viewport settings and idle/stall mixes; checking is done by the checker.
// ---------------------------------------------------------------------------
module point_to_pixel_projection_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import p2p_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = PIPE_LAT + 10;
   localparam int FX_ONE         = 1 << FRACTION_BITS;

   logic clock;
   logic reset;
   int   mismatches, pending;
   int   send_idle_pct, recv_stall_pct;
   int   quiet_cycles;

   p2p_req_if req_bus ();
   p2p_rsp_if rsp_bus ();
   p2p_csr_if csr_bus ();

   point_to_pixel_projection_unit dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   point_to_pixel_projection_checker checker_i (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus), .csr(csr_bus),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock)
      rsp_bus.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

   // ends the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic signed [IN_W-1:0] val,
                            logic signed [IN_W-1:0] px, logic signed [IN_W-1:0] py,
                            logic signed [IN_W-1:0] pz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.coef_index <= idx;
      req_bus.coef_value <= val;
      req_bus.point_x    <= px;
      req_bus.point_y    <= py;
      req_bus.point_z    <= pz;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic load_coef(int idx, int val);
      send_item(OP_LOAD, IDX_W'(idx), val, $urandom, $urandom, $urandom);
   endtask

   task automatic project(int px, int py, int pz);
      send_item(OP_POINT, IDX_W'($urandom), $urandom, px, py, pz);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_screen(logic idx, int px);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= CFG_W'(px);
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_identity();
      for (int i = 0; i < N_COEF; i++)
         load_coef(i, (i % 5 == 0) ? FX_ONE : 0);
   endtask

   function automatic int rand_coef();
      if ($urandom_range(99) < 25) return $urandom;
      return $urandom_range(8 * FX_ONE) - 4 * FX_ONE;
   endfunction

   function automatic int rand_coord();
      if ($urandom_range(99) < 30) return $urandom;
      return $urandom_range(2000 * FX_ONE) - 1000 * FX_ONE;
   endfunction

   task automatic random_phase(int n_items, int idle_pct, int stall_pct);
      int done;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      done = 0;
      while (done < n_items) begin
         if ($urandom_range(99) < 3) begin
            // quiet stretch inside the phase
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else if ($urandom_range(99) < 3) begin
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
         end
         if ($urandom_range(99) < 15) load_coef($urandom_range(15), rand_coef());
         else project(rand_coord(), rand_coord(), rand_coord());
         done++;
      end
      drain();
   endtask

   initial begin
      reset          = 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      req_bus.valid  = 1'b0;
      req_bus.operation  = OP_LOAD;
      req_bus.coef_index = '0;
      req_bus.coef_value = '0;
      req_bus.point_x    = '0;
      req_bus.point_y    = '0;
      req_bus.point_z    = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_SCREEN_WIDTH;
      csr_bus.data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset matrix and viewport
      project(0, 0, 0);
      project(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      project(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      project(-1, 1, FX_ONE);
      // w exactly zero and negative: behind camera
      load_coef(15, 0);
      project(FX_ONE, FX_ONE, FX_ONE);
      load_coef(11, -FX_ONE);
      project(5 * FX_ONE, -3 * FX_ONE, 2 * FX_ONE);
      // tiny w with huge x: quotient saturates
      load_coef(11, 0);
      load_coef(15, 1);
      project(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      load_coef(0, 32'h8000_0000);
      load_coef(5, 32'h7FFF_FFFF);
      project(32'h8000_0000, 32'h8000_0000, 1);
      // perspective style: w = -z
      load_identity();
      load_coef(11, -FX_ONE);
      load_coef(15, 0);
      project(3 * FX_ONE, 2 * FX_ONE, -10 * FX_ONE);
      // the sender holds off until every result is back
      drain();

      // extremes of the viewport, then a random one
      write_screen(CSR_SCREEN_WIDTH, 1);
      write_screen(CSR_SCREEN_HEIGHT, 1);
      random_phase(260, 0, 0);
      write_screen(CSR_SCREEN_WIDTH, 8192);
      write_screen(CSR_SCREEN_HEIGHT, 8192);
      random_phase(260, 77, 0);
      write_screen(CSR_SCREEN_WIDTH, 0);
      write_screen(CSR_SCREEN_HEIGHT, 16383);
      load_identity();
      random_phase(260, 0, 77);
      write_screen(CSR_SCREEN_WIDTH, $urandom_range(1, 8192));
      write_screen(CSR_SCREEN_HEIGHT, $urandom_range(1, 8192));
      random_phase(260, 19, 19);

      if (mismatches == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

>>> sim.f
rtl/core/p2p_pkg.sv
rtl/core/p2p_if.sv
rtl/core/p2p_lane.sv
rtl/core/point_to_pixel_projection_unit.sv
tb/point_to_pixel_projection_checker.sv
tb/point_to_pixel_projection_unit_tb.sv
